// ----- sv/lvas_pkg.sv -----
`timescale 1ns / 1ps
// Package of the LRU voice allocator: field widths, operation codes,
// register indexes and the packed voice record. No dependencies.
package lvas_pkg;

  localparam int VOICE_COUNT_DEF = 5;
  localparam int NOTE_W          = 7;
  localparam int AGE_W           = 32;
  localparam int OP_W            = 2;
  localparam int VOICE_W         = 3;
  localparam int MASK_W          = 5;
  localparam int PADDR_W         = 3;
  localparam int PDATA_W         = 32;

  localparam logic [PADDR_W-3:0] REG_GATE_RETRIGGER = '0;

  typedef enum logic [OP_W-1:0] {
    OP_NOTE_ON  = 2'd0,
    OP_NOTE_OFF = 2'd1,
    OP_PEDAL    = 2'd2,
    OP_PANIC    = 2'd3
  } op_e;

  typedef struct packed {
    logic [NOTE_W-1:0] note;
    logic [AGE_W-1:0]  age;
    logic              active;
    logic              held;
  } voice_t;

endpackage

// ----- sv/lvas_ram.sv -----
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module lvas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- sv/lru_voice_allocator_with_sustain.sv -----
`timescale 1ns / 1ps
// LRU voice allocator with sustain pedal. An event is accepted when start is high and busy is
// low; the voice RAM is then scanned serially through its single read port (state S_SCAN),
// then S_DRAIN and S_FINISH follow, and done_o, registered from S_FINISH, marks the result
// beat. busy stays high throughout, so no new event is taken before the last one is done. The
// receiver cannot stall the result. Reset clears the control state, the pedal flag, the
// register and the per-voice valid bits, so a voice that was never written reads as all zero.
module lru_voice_allocator_with_sustain
  import lvas_pkg::*;
#(
  parameter int VOICE_COUNT = VOICE_COUNT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     operation_i,
  input  logic [NOTE_W-1:0]   note_i,
  input  logic [AGE_W-1:0]    timestamp_i,
  input  logic                pedal_down_i,
  output logic                done_o,
  output logic                voice_started_o,
  output logic [VOICE_W-1:0]  voice_o,
  output logic                envelope_reset_o,
  output logic [MASK_W-1:0]   released_mask_o,
  output logic                clear_all_envelopes_o,
  output logic [MASK_W-1:0]   active_mask_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  localparam int IDX_W = $clog2(VOICE_COUNT);
  localparam int IW    = (IDX_W > VOICE_W) ? IDX_W : VOICE_W;
  localparam int MW    = (VOICE_COUNT > MASK_W) ? VOICE_COUNT : MASK_W;
  localparam int ENT_W = $bits(voice_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_e;

  state_e                  state_q;
  logic [IDX_W-1:0]        rd_idx_q;
  logic                    pv_q;
  logic [IDX_W-1:0]        pidx_q;
  op_e                     op_q;
  logic [NOTE_W-1:0]       note_q;
  logic [AGE_W-1:0]        ts_q;
  logic                    pdl_q;
  logic                    pedal_held_q;
  logic                    gate_q;
  logic [VOICE_COUNT-1:0]  valid_q;
  logic [MW-1:0]           before_q;
  logic [MW-1:0]           after_q;
  logic                    found_q;
  logic [IDX_W-1:0]        match_q;
  logic                    have_idle_q;
  logic [IDX_W-1:0]        idle_q;
  logic [AGE_W-1:0]        idle_age_q;
  logic                    have_busy_q;
  logic [IDX_W-1:0]        busy_q;
  logic [AGE_W-1:0]        busy_age_q;
  logic                    started_q;
  logic [VOICE_W-1:0]      voice_q;
  logic                    envr_q;
  logic [MASK_W-1:0]       rel_q;
  logic                    clr_q;
  logic [MASK_W-1:0]       act_q;

  logic                    accept;
  logic [ENT_W-1:0]        ram_rdata;
  voice_t                  cur;
  voice_t                  nxt;
  logic                    proc_wr;
  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  voice_t                  ram_wdata;
  logic [IDX_W-1:0]        sel;
  logic [IW-1:0]           sel_x;
  logic                    is_on;
  logic [MW-1:0]           am_d;
  logic [MW-1:0]           rm_d;
  logic                    note_hit;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1:2] == REG_GATE_RETRIGGER) ? PDATA_W'(gate_q) : '0;

  lvas_ram #(
    .WIDTH (ENT_W),
    .DEPTH (VOICE_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (state_q == S_SCAN),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    cur      = valid_q[pidx_q] ? voice_t'(ram_rdata) : '0;
    nxt      = cur;
    proc_wr  = 1'b0;
    note_hit = (cur.note == note_q);
    case (op_q)
      OP_NOTE_OFF: begin
        if (note_hit) begin
          proc_wr = 1'b1;
          if (pedal_held_q) begin
            nxt.held = 1'b1;
          end else begin
            nxt.age    = ts_q;
            nxt.active = 1'b0;
          end
        end
      end
      OP_PEDAL: begin
        if (!pdl_q && cur.held) begin
          proc_wr    = 1'b1;
          nxt.age    = ts_q;
          nxt.held   = 1'b0;
          nxt.active = 1'b0;
        end
      end
      OP_PANIC: begin
        proc_wr    = 1'b1;
        nxt.age    = '0;
        nxt.active = 1'b0;
      end
      default: begin
        proc_wr = 1'b0;
      end
    endcase
  end

  always_comb begin
    is_on = (op_q == OP_NOTE_ON);
    if (found_q) begin
      sel = match_q;
    end else if (have_idle_q) begin
      sel = idle_q;
    end else begin
      sel = busy_q;
    end
    sel_x = IW'(sel);
    am_d  = is_on ? (before_q | (MW'(1) << sel)) : after_q;
    rm_d  = before_q & ~am_d;
    if (state_q == S_FINISH) begin
      ram_we         = is_on;
      ram_waddr      = sel;
      ram_wdata      = '0;
      ram_wdata.note = note_q;
      ram_wdata.age  = ts_q;
      ram_wdata.active = 1'b1;
    end else begin
      ram_we    = pv_q && proc_wr;
      ram_waddr = pidx_q;
      ram_wdata = nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      rd_idx_q     <= '0;
      pv_q         <= 1'b0;
      pidx_q       <= '0;
      op_q         <= OP_NOTE_ON;
      note_q       <= '0;
      ts_q         <= '0;
      pdl_q        <= 1'b0;
      pedal_held_q <= 1'b0;
      gate_q       <= 1'b0;
      valid_q      <= '0;
      before_q     <= '0;
      after_q      <= '0;
      found_q      <= 1'b0;
      match_q      <= '0;
      have_idle_q  <= 1'b0;
      idle_q       <= '0;
      idle_age_q   <= '0;
      have_busy_q  <= 1'b0;
      busy_q       <= '0;
      busy_age_q   <= '0;
      done_o       <= 1'b0;
      started_q    <= 1'b0;
      voice_q      <= '0;
      envr_q       <= 1'b0;
      rel_q        <= '0;
      clr_q        <= 1'b0;
      act_q        <= '0;
    end else begin
      done_o <= (state_q == S_FINISH);
      if (psel && penable && pwrite && pready
          && paddr[PADDR_W-1:2] == REG_GATE_RETRIGGER) begin
        gate_q <= pwdata[0];
      end
      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
      pv_q   <= (state_q == S_SCAN);
      pidx_q <= rd_idx_q;
      if (pv_q) begin
        before_q[pidx_q] <= cur.active;
        after_q[pidx_q]  <= nxt.active;
        if (note_hit && !found_q) begin
          found_q <= 1'b1;
          match_q <= pidx_q;
        end
        if (cur.active) begin
          if (!have_busy_q || cur.age < busy_age_q) begin
            have_busy_q <= 1'b1;
            busy_q      <= pidx_q;
            busy_age_q  <= cur.age;
          end
        end else begin
          if (!have_idle_q || cur.age < idle_age_q) begin
            have_idle_q <= 1'b1;
            idle_q      <= pidx_q;
            idle_age_q  <= cur.age;
          end
        end
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q     <= S_SCAN;
            rd_idx_q    <= '0;
            op_q        <= op_e'(operation_i);
            note_q      <= note_i;
            ts_q        <= timestamp_i;
            pdl_q       <= pedal_down_i;
            before_q    <= '0;
            after_q     <= '0;
            found_q     <= 1'b0;
            have_idle_q <= 1'b0;
            have_busy_q <= 1'b0;
            if (op_e'(operation_i) == OP_PEDAL) begin
              pedal_held_q <= pedal_down_i;
            end
          end
        end
        S_SCAN: begin
          rd_idx_q <= rd_idx_q + IDX_W'(1);
          if (rd_idx_q == IDX_W'(VOICE_COUNT - 1)) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_q <= S_FINISH;
        end
        S_FINISH: begin
          state_q   <= S_IDLE;
          started_q <= is_on;
          voice_q   <= is_on ? sel_x[VOICE_W-1:0] : '0;
          envr_q    <= is_on && gate_q;
          rel_q     <= rm_d[MASK_W-1:0];
          clr_q     <= (op_q == OP_PANIC);
          act_q     <= am_d[MASK_W-1:0];
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign voice_started_o       = started_q;
  assign voice_o               = voice_q;
  assign envelope_reset_o      = envr_q;
  assign released_mask_o       = rel_q;
  assign clear_all_envelopes_o = clr_q;
  assign active_mask_o         = act_q;

`ifndef SYNTHESIS
  a_no_proc_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> !pv_q)
    else $error("voice data in flight while the allocator is idle");

  a_done_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == S_FINISH))
    else $error("result beat without a finished scan");

  a_masks_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (released_mask_o & active_mask_o) == '0)
    else $error("a voice is both released and active");

  a_no_rw_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && state_q == S_SCAN) |-> ram_waddr != rd_idx_q)
    else $error("voice RAM read and written at the same entry");
`endif

endmodule
